>>> hw/rtl/hff_pkg.sv
// Package for the hex field formatter: character codes, control word types,
// the microcode program and the hex digit encoder.
// No dependencies; imported by hex_field_formatter and its testbench.
package hff_pkg;

    localparam int MAX_CHARS_DEF = 64;
    localparam int CNT_W         = 7;
    localparam int PC_W          = 4;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [PC_W-1:0]  pc_t;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;

    localparam logic [1:0] MODE_W32 = 2'd0;
    localparam logic [1:0] MODE_W64 = 2'd1;
    localparam logic [1:0] MODE_W16 = 2'd2;

    typedef enum logic [2:0] {
        OP_ND,
        OP_LEN,
        OP_PAD,
        OP_TOT,
        OP_EMIT,
        OP_END
    } op_t;

    typedef enum logic [1:0] {
        SRC_PAD,
        SRC_ZERO,
        SRC_XLET,
        SRC_DIGIT
    } src_t;

    typedef enum logic [2:0] {
        CNT_NONE,
        CNT_LPAD,
        CNT_FILL,
        CNT_PRE,
        CNT_DIGITS,
        CNT_RPAD
    } cnt_sel_t;

    typedef struct packed {
        op_t      op;
        src_t     src;
        cnt_sel_t cnt;
        pc_t      jmp;
    } ctrl_t;

    localparam pc_t PC_END = 4'd10;

    // Program: four setup steps, then one emit loop per part of the field, two for the prefix.
    function automatic ctrl_t hff_ucode(input pc_t pc);
        ctrl_t c;
        c = '{op: OP_END, src: SRC_PAD, cnt: CNT_NONE, jmp: PC_END};
        case (pc)
            4'd0:  c = '{op: OP_ND,   src: SRC_PAD,   cnt: CNT_NONE,   jmp: PC_END};
            4'd1:  c = '{op: OP_LEN,  src: SRC_PAD,   cnt: CNT_NONE,   jmp: PC_END};
            4'd2:  c = '{op: OP_PAD,  src: SRC_PAD,   cnt: CNT_NONE,   jmp: PC_END};
            4'd3:  c = '{op: OP_TOT,  src: SRC_PAD,   cnt: CNT_NONE,   jmp: PC_END};
            4'd4:  c = '{op: OP_EMIT, src: SRC_PAD,   cnt: CNT_LPAD,   jmp: PC_END};
            4'd5:  c = '{op: OP_EMIT, src: SRC_ZERO,  cnt: CNT_FILL,   jmp: PC_END};
            4'd6:  c = '{op: OP_EMIT, src: SRC_ZERO,  cnt: CNT_PRE,    jmp: PC_END};
            4'd7:  c = '{op: OP_EMIT, src: SRC_XLET,  cnt: CNT_PRE,    jmp: PC_END};
            4'd8:  c = '{op: OP_EMIT, src: SRC_DIGIT, cnt: CNT_DIGITS, jmp: PC_END};
            4'd9:  c = '{op: OP_EMIT, src: SRC_PAD,   cnt: CNT_RPAD,   jmp: PC_END};
            default: c = '{op: OP_END, src: SRC_PAD, cnt: CNT_NONE, jmp: PC_END};
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hff_hex_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_A_UP : CH_A_LO;
        if (d < 4'd10) begin
            return CH_ZERO + {4'd0, d};
        end
        return base + {4'd0, d} - 8'd10;
    endfunction

endpackage

>>> hw/rtl/hex_field_formatter.sv
// Hex field formatter top level: a microcoded sequencer that turns one value
// into a padded hex text field, one character per output item.
// Depends on hff_pkg.
//
// Usage: an input item (value, size mode, case, flags, width, precision) is
// taken on the s_ channel when s_valid and s_ready are high. The block then
// runs a short program from a control ROM: four setup steps work out the digit
// count, precision fill, width padding and total length, and then one emit
// loop per part of the field (left padding, precision zeros, prefix 0, prefix
// x, digits, right padding) places the characters into the output register,
// one per cycle while the output is not stalled. m_last marks the final
// character of the item. A zero value without prefix and with precision zero
// produces no output item at all. An item runs the setup steps, places its N
// characters (N at most 63 and MAX_CHARS) loop by loop and ends at the last;
// an empty field ends after the length step. s_ready goes high again once the
// last character sits in the output register, so the next item is taken
// while that character still waits. When m_ready is low and a character
// waits, the sequencer stops at its next character and loses nothing.
// Reset (synchronous, aresetn low) empties the output register and idles the
// sequencer.
module hex_field_formatter
    import hff_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [63:0]       s_value,
    input  logic [1:0]        s_mode,
    input  logic              s_upper_case,
    input  logic              s_alt_prefix,
    input  logic              s_zero_pad,
    input  logic              s_left_justify,
    input  logic [5:0]        s_field_width,
    input  logic signed [5:0] s_precision,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_char_out,
    output logic              m_last
);

    localparam int   LIMIT_I = (MAX_CHARS > 64) ? 64 : MAX_CHARS;
    localparam cnt_t LIMIT   = cnt_t'(LIMIT_I);

    logic        busy_reg, busy_next;
    pc_t         pc_reg, pc_next;
    cnt_t        idx_reg, idx_next;
    cnt_t        emitted_reg, emitted_next;
    logic [63:0] num_reg, num_next;
    logic        upper_reg, upper_next;
    logic        pre_reg, pre_next;
    logic        zpad_reg, zpad_next;
    logic        left_reg, left_next;
    logic [5:0]  width_reg, width_next;
    logic [5:0]  prec_reg, prec_next;
    logic [4:0]  nd_reg, nd_next;
    logic [3:0]  dig_reg, dig_next;
    cnt_t        len_reg, len_next;
    cnt_t        fill_reg, fill_next;
    cnt_t        pad_reg, pad_next;
    cnt_t        eff_reg, eff_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_char_reg, m_char_next;
    logic        m_last_reg, m_last_next;

    ctrl_t       ctrl;
    logic        out_free;
    cnt_t        cnt_val;
    logic [3:0]  hi;
    cnt_t        len_v;
    cnt_t        prec_v;
    cnt_t        body_v;
    cnt_t        width_v;
    cnt_t        tot_v;
    logic [7:0]  ch;
    logic [63:0] trunc_v;

    assign s_ready    = !busy_reg;
    assign m_valid    = m_valid_reg;
    assign m_char_out = m_char_reg;
    assign m_last     = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pc_reg      <= '0;
            idx_reg     <= '0;
            emitted_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            pc_reg      <= pc_next;
            idx_reg     <= idx_next;
            emitted_reg <= emitted_next;
            m_valid_reg <= m_valid_next;
        end
        num_reg    <= num_next;
        upper_reg  <= upper_next;
        pre_reg    <= pre_next;
        zpad_reg   <= zpad_next;
        left_reg   <= left_next;
        width_reg  <= width_next;
        prec_reg   <= prec_next;
        nd_reg     <= nd_next;
        dig_reg    <= dig_next;
        len_reg    <= len_next;
        fill_reg   <= fill_next;
        pad_reg    <= pad_next;
        eff_reg    <= eff_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    always_comb begin
        busy_next    = busy_reg;
        pc_next      = pc_reg;
        idx_next     = idx_reg;
        emitted_next = emitted_reg;
        num_next     = num_reg;
        upper_next   = upper_reg;
        pre_next     = pre_reg;
        zpad_next    = zpad_reg;
        left_next    = left_reg;
        width_next   = width_reg;
        prec_next    = prec_reg;
        nd_next      = nd_reg;
        dig_next     = dig_reg;
        len_next     = len_reg;
        fill_next    = fill_reg;
        pad_next     = pad_reg;
        eff_next     = eff_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;

        ctrl     = hff_ucode(pc_reg);
        out_free = !m_valid_reg || m_ready;
        hi       = '0;
        width_v  = {1'b0, width_reg};
        prec_v   = {1'b0, prec_reg};
        len_v    = cnt_t'(nd_reg) + (pre_reg ? cnt_t'(2) : cnt_t'(0));
        body_v   = len_reg + fill_reg;
        tot_v    = (width_v > len_reg) ? width_v : len_reg;

        case (s_mode)
            MODE_W64: trunc_v = s_value;
            MODE_W16: trunc_v = {48'd0, s_value[15:0]};
            default:  trunc_v = {32'd0, s_value[31:0]};
        endcase

        case (ctrl.cnt)
            CNT_LPAD:   cnt_val = left_reg ? '0 : pad_reg;
            CNT_RPAD:   cnt_val = left_reg ? pad_reg : '0;
            CNT_FILL:   cnt_val = fill_reg;
            CNT_PRE:    cnt_val = cnt_t'(pre_reg);
            CNT_DIGITS: cnt_val = cnt_t'(nd_reg);
            default:    cnt_val = '0;
        endcase

        case (ctrl.src)
            SRC_PAD:   ch = (zpad_reg && !left_reg) ? CH_ZERO : CH_SPACE;
            SRC_ZERO:  ch = CH_ZERO;
            SRC_XLET:  ch = upper_reg ? CH_X_UP : CH_X_LO;
            SRC_DIGIT: ch = hff_hex_char(num_reg[{dig_reg, 2'b00} +: 4], upper_reg);
            default:   ch = CH_SPACE;
        endcase

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (!busy_reg) begin
            if (s_valid) begin
                busy_next    = 1'b1;
                pc_next      = '0;
                idx_next     = '0;
                emitted_next = '0;
                num_next     = trunc_v;
                upper_next   = s_upper_case;
                pre_next     = s_alt_prefix && (s_value != 64'd0);
                zpad_next    = s_zero_pad;
                left_next    = s_left_justify;
                width_next   = s_field_width;
                prec_next    = s_precision;
            end
        end else begin
            case (ctrl.op)
                OP_ND: begin
                    // Highest nonzero nibble sets the digit count; zero gives one digit.
                    for (int i = 0; i < 16; i++) begin
                        if (num_reg[i*4 +: 4] != 4'd0) begin
                            hi = 4'(i);
                        end
                    end
                    nd_next  = {1'b0, hi} + 5'd1;
                    dig_next = hi;
                    pc_next  = pc_reg + pc_t'(1);
                end
                OP_LEN: begin
                    len_next  = len_v;
                    fill_next = (!prec_reg[5] && prec_v > len_v) ? prec_v - len_v : '0;
                    if (num_reg == 64'd0 && !pre_reg && prec_reg == 6'd0) begin
                        pc_next = ctrl.jmp;
                    end else begin
                        pc_next = pc_reg + pc_t'(1);
                    end
                end
                OP_PAD: begin
                    len_next = body_v;
                    pad_next = (width_v > body_v) ? width_v - body_v : '0;
                    pc_next  = pc_reg + pc_t'(1);
                end
                OP_TOT: begin
                    eff_next = (tot_v > LIMIT) ? LIMIT : tot_v;
                    idx_next = '0;
                    pc_next  = pc_reg + pc_t'(1);
                end
                OP_EMIT: begin
                    if (idx_reg >= cnt_val) begin
                        pc_next  = pc_reg + pc_t'(1);
                        idx_next = '0;
                    end else if (out_free) begin
                        m_valid_next = 1'b1;
                        m_char_next  = ch;
                        m_last_next  = (emitted_reg + cnt_t'(1)) == eff_reg;
                        idx_next     = idx_reg + cnt_t'(1);
                        emitted_next = emitted_reg + cnt_t'(1);
                        if (ctrl.src == SRC_DIGIT) begin
                            dig_next = dig_reg - 4'd1;
                        end
                        // The character cap can end the field in any part.
                        if ((emitted_reg + cnt_t'(1)) == eff_reg) begin
                            busy_next = 1'b0;
                        end
                    end
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

endmodule

>>> dv/hex_field_formatter_tb.sv
// Testbench for hex_field_formatter: drives formatting requests and checks every
// emitted character against a scoreboard that formats the same requests itself.
// Depends on hff_pkg and the hex_field_formatter RTL.
module hex_field_formatter_tb;
    import hff_pkg::*;

    localparam logic [1:0]        MODE_UNUSED    = 2'd3;
    localparam logic signed [5:0] PREC_NONE      = 6'sb111111;
    localparam logic signed [5:0] PREC_MOST_NEG  = 6'sb100000;
    localparam logic signed [5:0] PREC_MAX       = 6'sd31;
    localparam int                RX_HOLD_CYCLES = 400;
    localparam int                QUIET_LIMIT    = 4000;
    localparam int                DRAIN_CYCLES   = 40;

    // Formats each accepted request into its expected characters and checks
    // the emitted characters against them in order.
    class hex_text_scoreboard;
        typedef struct packed {
            logic [7:0] ch;
            logic       last;
        } text_char_t;

        text_char_t field_chars[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        function void note_item(input logic [63:0] value, input logic [1:0] mode,
                                input logic upper, input logic alt, input logic zpad,
                                input logic left, input logic [5:0] width,
                                input logic signed [5:0] precision);
            logic [63:0] num;
            logic [7:0]  digits[$];
            logic [7:0]  text[$];
            logic [7:0]  line[$];
            logic [7:0]  pad_ch;
            logic [3:0]  nib;
            logic        has_prefix;
            int          prec;
            int          body_len;
            int          pad;
            text_char_t  tc;

            case (mode)
                MODE_W64: num = value;
                MODE_W16: num = {48'd0, value[15:0]};
                default:  num = {32'd0, value[31:0]};
            endcase
            has_prefix = alt && (value != 64'd0);
            prec = int'(precision);

            if (num == 64'd0) begin
                digits.push_back(CH_ZERO);
            end
            while (num != 64'd0) begin
                nib = num[3:0];
                if (nib < 4'd10) begin
                    digits.push_front(CH_ZERO + 8'(nib));
                end else begin
                    digits.push_front((upper ? CH_A_UP : CH_A_LO) + 8'(nib) - 8'd10);
                end
                num = num >> 4;
            end

            body_len = digits.size() + (has_prefix ? 2 : 0);
            // A bare zero with precision zero produces an empty field.
            if (prec == 0 && body_len == 1 && digits[0] == CH_ZERO) begin
                return;
            end

            // Precision zeros go in front of the prefix.
            for (int i = body_len; i < prec; i++) begin
                text.push_back(CH_ZERO);
            end
            if (has_prefix) begin
                text.push_back(CH_ZERO);
                text.push_back(upper ? CH_X_UP : CH_X_LO);
            end
            foreach (digits[i]) begin
                text.push_back(digits[i]);
            end

            pad_ch = (zpad && !left) ? CH_ZERO : CH_SPACE;
            pad = (int'(width) > text.size()) ? int'(width) - text.size() : 0;
            if (left) begin
                line = text;
                repeat (pad) line.push_back(pad_ch);
            end else begin
                repeat (pad) line.push_back(pad_ch);
                foreach (text[i]) begin
                    line.push_back(text[i]);
                end
            end

            foreach (line[i]) begin
                if (i < MAX_CHARS_DEF) begin
                    tc.ch   = line[i];
                    tc.last = (i == line.size() - 1) || (i == MAX_CHARS_DEF - 1);
                    field_chars.push_back(tc);
                end
            end
        endfunction

        function void check_char(input logic [7:0] ch, input logic last);
            text_char_t tc;
            if (field_chars.size() == 0) begin
                $display("%0t: unexpected character: expected none actual %02h last %0b",
                         $time, ch, last);
                errors++;
                return;
            end
            tc = field_chars.pop_front();
            if (ch !== tc.ch) begin
                $display("%0t: char_out mismatch: expected %02h actual %02h",
                         $time, tc.ch, ch);
                errors++;
            end
            if (last !== tc.last) begin
                $display("%0t: last mismatch: expected %0b actual %0b",
                         $time, tc.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return field_chars.size();
        endfunction

        function void report_leftover();
            if (field_chars.size() != 0) begin
                $display("%0t: %0d expected characters never arrived",
                         $time, field_chars.size());
                errors += field_chars.size();
            end
        endfunction
    endclass

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [63:0]       s_value        = '0;
    logic [1:0]        s_mode         = MODE_W32;
    logic              s_upper_case   = 1'b0;
    logic              s_alt_prefix   = 1'b0;
    logic              s_zero_pad     = 1'b0;
    logic              s_left_justify = 1'b0;
    logic [5:0]        s_field_width  = '0;
    logic signed [5:0] s_precision    = '0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [7:0]        m_char_out;
    logic              m_last;

    hex_text_scoreboard text_sb = new();

    bit rx_steady   = 1'b0;
    bit rx_hold_req = 1'b0;
    int rx_stall_left = 0;
    int quiet_cycles  = 0;

    hex_field_formatter i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .s_mode         (s_mode),
        .s_upper_case   (s_upper_case),
        .s_alt_prefix   (s_alt_prefix),
        .s_zero_pad     (s_zero_pad),
        .s_left_justify (s_left_justify),
        .s_field_width  (s_field_width),
        .s_precision    (s_precision),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_char_out     (m_char_out),
        .m_last         (m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            text_sb.note_item(s_value, s_mode, s_upper_case, s_alt_prefix, s_zero_pad,
                              s_left_justify, s_field_width, s_precision);
        end
        if (aresetn && m_valid && m_ready) begin
            text_sb.check_char(m_char_out, m_last);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("hex_field_formatter test failed");
            $finish;
        end
    end

    // Output side: random stalls, a long hold-off on request, or always ready.
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                rx_hold_req   = 1'b0;
                rx_stall_left = RX_HOLD_CYCLES;
            end
            if (rx_stall_left > 0) begin
                m_ready = 1'b0;
                rx_stall_left--;
            end else begin
                m_ready = 1'b1;
                if (!rx_steady && $urandom_range(0, 4) == 0) begin
                    rx_stall_left = pick_gap();
                end
            end
        end
    end

    task automatic send_item(input logic [63:0] value, input logic [1:0] mode,
                             input logic upper, input logic alt, input logic zpad,
                             input logic left, input logic [5:0] width,
                             input logic signed [5:0] prec);
        @(negedge aclk);
        s_value        = value;
        s_mode         = mode;
        s_upper_case   = upper;
        s_alt_prefix   = alt;
        s_zero_pad     = zpad;
        s_left_justify = left;
        s_field_width  = width;
        s_precision    = prec;
        s_valid        = 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    task automatic idle_tx(input int cycles);
        if (cycles > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            s_value = {$urandom, $urandom};
            repeat (cycles - 1) @(negedge aclk);
        end
    endtask

    task automatic send_random_item();
        logic [63:0]       value;
        logic [5:0]        width;
        logic signed [5:0] prec;
        int                r;

        r = $urandom_range(0, 9);
        case (r)
            0: value = 64'd0;
            // Values whose low 16 bits are clear, so they truncate to zero in the 16-bit mode.
            1: value = {$urandom, 32'd0} >> $urandom_range(0, 16);
            2: value = 64'($urandom_range(0, 65535));
            3: value = 64'($urandom_range(0, 15));
            default: value = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        width = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 24));
        r = $urandom_range(0, 9);
        if (r < 3) begin
            prec = PREC_NONE;
        end else if (r < 5) begin
            prec = '0;
        end else begin
            prec = 6'($urandom_range(0, 63));
        end
        send_item(value, 2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                  1'($urandom), 1'($urandom), width, prec);
    endtask

    // Waits for the falling edge first, so that an item taken at the last rising
    // edge is already noted by the scoreboard.
    task automatic wait_drained();
        @(negedge aclk);
        while (text_sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty fields, truncated zeros with prefix, size modes,
        // precision extremes and every padding style at full width.
        send_item(64'd0, MODE_W32, 0, 0, 0, 0, 6'd0, 6'sd0);
        idle_tx(pick_gap());
        send_item(64'd0, MODE_W64, 0, 1, 0, 0, 6'd5, 6'sd0);
        send_item(64'd0, MODE_W32, 0, 1, 0, 0, 6'd0, PREC_NONE);
        idle_tx(pick_gap());
        send_item(64'h1_0000_0000, MODE_W32, 0, 1, 0, 0, 6'd0, PREC_NONE);
        send_item(64'h1_0000_0000, MODE_W32, 0, 0, 0, 0, 6'd0, 6'sd0);
        send_item(64'h1_0000, MODE_W16, 1, 1, 0, 0, 6'd0, 6'sd0);
        idle_tx(pick_gap());
        send_item('1, MODE_W64, 1, 1, 0, 0, 6'd0, PREC_NONE);
        send_item('1, MODE_W64, 0, 0, 0, 0, 6'd0, PREC_NONE);
        send_item(64'hDEAD_BEEF_CAFE_F00D, MODE_UNUSED, 0, 1, 0, 0, 6'd0, PREC_NONE);
        idle_tx(pick_gap());
        send_item(64'h1234_5678_9ABC_DEF0, MODE_W16, 1, 0, 0, 0, 6'd0, PREC_NONE);
        send_item(64'hABC, MODE_W32, 0, 1, 0, 0, 6'd0, PREC_MAX);
        send_item(64'hABC, MODE_W32, 0, 0, 0, 0, 6'd0, PREC_MOST_NEG);
        idle_tx(pick_gap());
        send_item(64'hABC, MODE_W32, 0, 1, 1, 0, 6'd63, PREC_NONE);
        send_item(64'hABC, MODE_W32, 1, 1, 1, 1, 6'd63, PREC_NONE);
        send_item(64'hABC, MODE_W32, 0, 0, 0, 0, 6'd63, PREC_NONE);
        idle_tx(pick_gap());
        send_item(64'h5, MODE_W32, 0, 1, 1, 0, 6'd63, PREC_MAX);
        send_item(64'd0, MODE_W32, 0, 0, 1, 0, 6'd10, PREC_NONE);
        send_item(64'd0, MODE_W32, 0, 0, 0, 1, 6'd10, 6'sd3);
        send_item(64'h7, MODE_W64, 0, 1, 0, 0, 6'd2, 6'sd2);
        idle_tx(pick_gap());

        repeat (100) begin
            send_random_item();
            idle_tx(pick_gap());
        end

        // Let everything drain before going on.
        wait_drained();

        // The output side holds off while items keep coming, so the block
        // backs up and stops taking input.
        rx_hold_req = 1'b1;
        repeat (20) send_random_item();

        rx_steady = 1'b1;
        repeat (60) send_random_item();
        rx_steady = 1'b0;

        repeat (190) begin
            send_random_item();
            idle_tx(pick_gap());
        end

        @(negedge aclk);
        s_valid = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        text_sb.report_leftover();
        if (text_sb.errors == 0) begin
            $display("hex_field_formatter test passed");
        end else begin
            $display("hex_field_formatter test failed");
        end
        $finish;
    end

endmodule
